[hdl/rc4bw_pkg.sv]
// Package for the bounded word generator: shared widths, defaults and action codes.
// No dependencies; imported by the interfaces, remainder unit, sequencer and top level.

package rc4bw_pkg;

    localparam int WORD_BYTES_DEF = 4;
    localparam int DATA_W = 32;
    localparam int IDX_W = 8;
    localparam int SLOTS = 256;

    localparam logic ACT_SEED = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

endpackage

[hdl/rc4bw_ifs.sv]
// Valid/ready channel interfaces of the bounded word generator: command in, word out.
// Depends on rc4bw_pkg for the payload widths.

interface rc4bw_in_if import rc4bw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [DATA_W-1:0] seed_value;
    logic [DATA_W-1:0] bound;

    modport source (output valid, output action, output seed_value, output bound, input ready);
    modport sink (input valid, input action, input seed_value, input bound, output ready);
endinterface

interface rc4bw_out_if import rc4bw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] word_count;

    modport source (output valid, output value, output word_count, input ready);
    modport sink (input valid, input value, input word_count, output ready);
endinterface

[hdl/rc4bw_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.

module rc4bw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/rc4bw_mod.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle against a 32-bit divisor.
// Depends on rc4bw_pkg for the result width.

module rc4bw_mod import rc4bw_pkg::*; #(
    parameter int WW = 8 * WORD_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WW-1:0]     dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] remainder
);

    localparam int CNT_W = $clog2(WW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WW-1:0]     quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] div_reg, div_next;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_sub;

    // Shift the next dividend bit in and subtract when the partial remainder allows it.
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[WW-1]};
        rem_sub = rem_sh - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WW);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = quo_reg << 1;
            rem_next = (rem_sh >= {1'b0, div_reg}) ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hdl/rc4bw_core.sv]
// Sequencer of the generator: key schedule, keystream bytes, output register.
// Depends on rc4bw_pkg and the channel interfaces; drives the permutation RAM and remainder unit.

module rc4bw_core import rc4bw_pkg::*; #(
    parameter int WORD_BYTES = WORD_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rc4bw_in_if.sink             cmd,
    rc4bw_out_if.source          res,
    output logic                 ram_we,
    output logic [IDX_W-1:0]     ram_waddr,
    output logic [IDX_W-1:0]     ram_wdata,
    output logic [IDX_W-1:0]     ram_raddr,
    input  logic [IDX_W-1:0]     ram_rdata,
    output logic                 mod_start,
    output logic [8*WORD_BYTES-1:0] mod_dividend,
    output logic [DATA_W-1:0]    mod_divisor,
    input  logic                 mod_done,
    input  logic [DATA_W-1:0]    mod_rem
);

    localparam int WW  = 8 * WORD_BYTES;
    localparam int SH_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FILL = 4'd1;
    localparam logic [3:0] ST_K_RD = 4'd2;
    localparam logic [3:0] ST_K_J  = 4'd3;
    localparam logic [3:0] ST_K_WN = 4'd4;
    localparam logic [3:0] ST_K_WJ = 4'd5;
    localparam logic [3:0] ST_D_RD = 4'd6;
    localparam logic [3:0] ST_D_J  = 4'd7;
    localparam logic [3:0] ST_D_WI = 4'd8;
    localparam logic [3:0] ST_D_WJ = 4'd9;
    localparam logic [3:0] ST_D_Q  = 4'd10;
    localparam logic [3:0] ST_MOD  = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  n_reg, n_next;
    logic [SH_W-1:0]   sh_reg, sh_next;
    logic [SH_W-1:0]   b_reg, b_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  si_reg, si_next;
    logic [IDX_W-1:0]  sj_reg, sj_next;
    logic              fwd_reg, fwd_next;
    logic [DATA_W-1:0] seed_reg, seed_next;
    logic [DATA_W-1:0] bound_reg, bound_next;
    logic [DATA_W-1:0] cnt_reg, cnt_next;
    logic [WW-1:0]     word_reg, word_next;
    logic [DATA_W-1:0] result_reg, result_next;
    logic [SLOTS-1:0]  vld_reg, vld_next;
    logic              rvld_reg;
    logic              ovalid_reg, ovalid_next;
    logic [DATA_W-1:0] oval_reg, oval_next;
    logic [DATA_W-1:0] ocnt_reg, ocnt_next;

    logic [IDX_W-1:0]  rd;
    logic [IDX_W-1:0]  kb;
    logic [IDX_W-1:0]  t_addr;
    logic [IDX_W-1:0]  q_byte;
    logic [WW+7:0]     word_cat;

    // Entries never written since reset read as zero.
    assign rd       = rvld_reg ? ram_rdata : '0;
    assign kb       = IDX_W'(seed_reg >> sh_reg);
    assign t_addr   = si_reg + sj_reg;
    assign q_byte   = fwd_reg ? si_reg : rd;
    assign word_cat = {q_byte, word_reg};

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign res.valid      = ovalid_reg;
    assign res.value      = oval_reg;
    assign res.word_count = ocnt_reg;

    assign mod_dividend = word_cat[WW+7:8];
    assign mod_divisor  = bound_reg;

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        sh_next     = sh_reg;
        b_next      = b_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        si_next     = si_reg;
        sj_next     = sj_reg;
        fwd_next    = fwd_reg;
        seed_next   = seed_reg;
        bound_next  = bound_reg;
        cnt_next    = cnt_reg;
        word_next   = word_reg;
        result_next = result_reg;
        ovalid_next = ovalid_reg;
        oval_next   = oval_reg;
        ocnt_next   = ocnt_reg;
        ram_we      = 1'b0;
        ram_waddr   = n_reg;
        ram_wdata   = n_reg;
        ram_raddr   = i_reg;
        mod_start   = 1'b0;

        if (ovalid_reg && res.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.action == ACT_SEED)
                    begin
                        seed_next  = cmd.seed_value;
                        n_next     = '0;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        bound_next = cmd.bound;
                        cnt_next   = cnt_reg + DATA_W'(1);
                        b_next     = '0;
                        state_next = ST_D_RD;
                    end
                end
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = n_reg;
                ram_wdata = n_reg;
                n_next    = n_reg + IDX_W'(1);
                if (n_reg == IDX_W'(SLOTS - 1))
                begin
                    j_next     = '0;
                    sh_next    = '0;
                    state_next = ST_K_RD;
                end
            end
            ST_K_RD:
            begin
                ram_raddr  = n_reg;
                state_next = ST_K_J;
            end
            ST_K_J:
            begin
                si_next    = rd;
                j_next     = j_reg + rd + kb;
                ram_raddr  = j_next;
                state_next = ST_K_WN;
            end
            ST_K_WN:
            begin
                ram_we     = 1'b1;
                ram_waddr  = n_reg;
                ram_wdata  = rd;
                state_next = ST_K_WJ;
            end
            ST_K_WJ:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                n_next    = n_reg + IDX_W'(1);
                sh_next   = (sh_reg == SH_W'(WORD_BYTES - 1)) ? '0 : sh_reg + SH_W'(1);
                if (n_reg == IDX_W'(SLOTS - 1))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_K_RD;
                end
            end
            ST_D_RD:
            begin
                ram_raddr  = i_reg;
                state_next = ST_D_J;
            end
            ST_D_J:
            begin
                si_next    = rd;
                j_next     = j_reg + rd;
                ram_raddr  = j_next;
                state_next = ST_D_WI;
            end
            ST_D_WI:
            begin
                sj_next    = rd;
                ram_we     = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = rd;
                state_next = ST_D_WJ;
            end
            ST_D_WJ:
            begin
                // The output lookup may hit the entry written in this same cycle.
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                ram_wdata  = si_reg;
                ram_raddr  = t_addr;
                fwd_next   = (t_addr == j_reg);
                state_next = ST_D_Q;
            end
            ST_D_Q:
            begin
                word_next = word_cat[WW+7:8];
                i_next    = i_reg + IDX_W'(1);
                if (b_reg == SH_W'(WORD_BYTES - 1))
                begin
                    if (bound_reg == '0)
                    begin
                        result_next = DATA_W'(word_cat[WW+7:8]);
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = ST_MOD;
                    end
                end
                else
                begin
                    b_next     = b_reg + SH_W'(1);
                    state_next = ST_D_RD;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    result_next = mod_rem;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || res.ready)
                begin
                    ovalid_next = 1'b1;
                    oval_next   = result_reg;
                    ocnt_next   = cnt_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        vld_next = vld_reg;
        if (ram_we)
        begin
            vld_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            n_reg      <= '0;
            sh_reg     <= '0;
            b_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            cnt_reg    <= '0;
            vld_reg    <= '0;
            rvld_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            sh_reg     <= sh_next;
            b_reg      <= b_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            cnt_reg    <= cnt_next;
            vld_reg    <= vld_next;
            rvld_reg   <= vld_reg[ram_raddr];
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg     <= si_next;
        sj_reg     <= sj_next;
        fwd_reg    <= fwd_next;
        seed_reg   <= seed_next;
        bound_reg  <= bound_next;
        word_reg   <= word_next;
        result_reg <= result_next;
        oval_reg   <= oval_next;
        ocnt_reg   <= ocnt_next;
    end

endmodule

[hdl/rc4_variant_bounded_word_generator.sv]
// Top level of the bounded word generator: permutation RAM, sequencer and remainder unit.
// Depends on rc4bw_pkg, rc4bw_ifs, rc4bw_ram, rc4bw_mod and rc4bw_core.
//
//   Channel  Direction  Handshake      Payload
//   cmd      in         valid/ready    action, seed_value, bound
//   res      out        valid/ready    value, word_count
//
// A draw is taken in the idle cycle. Each byte of its word uses the one-read, one-write
// permutation RAM in turn: read S[i], read S[j], write S[i], write S[j] with the output
// lookup, take the byte. When bound is nonzero the word then passes the bit-serial remainder
// unit before it reaches the output register; a new command is accepted only once the
// sequencer is idle again. A seed item fills every entry with its own index and then runs
// one swap per entry: read S[n], read S[j], write S[n], write S[j]. It gives no word.
// Reset clears the indices, the word counter and a per-entry valid flag of the
// permutation RAM; an entry never written reads as zero, so no clearing pass is needed.
// A finished word waits in the output register; a draw finishing while that register is
// still full holds until the sink takes the earlier word.

module rc4_variant_bounded_word_generator import rc4bw_pkg::*; #(
    parameter int WORD_BYTES = WORD_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rc4bw_in_if.sink    cmd,
    rc4bw_out_if.source res
);

    localparam int WW = 8 * WORD_BYTES;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [IDX_W-1:0]  ram_rdata;
    logic              mod_start;
    logic [WW-1:0]     mod_dividend;
    logic [DATA_W-1:0] mod_divisor;
    logic              mod_done;
    logic [DATA_W-1:0] mod_rem;

    // The byte permutation lives in one synchronous RAM with a registered read.
    rc4bw_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_perm (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The drawn word is reduced at its full width before it is cut to 32 bits.
    rc4bw_mod #(
        .WW (WW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    rc4bw_core #(
        .WORD_BYTES (WORD_BYTES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .res          (res),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .mod_start    (mod_start),
        .mod_dividend (mod_dividend),
        .mod_divisor  (mod_divisor),
        .mod_done     (mod_done),
        .mod_rem      (mod_rem)
    );

endmodule
